// ===== sv/assert_macros.svh =====
// shared assertion macros for the scorer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/fss_pkg.sv =====
package fss_pkg;

    localparam int SUM_W   = 48;
    localparam int NUM_W   = 54;
    localparam int FRAC_W  = 16;
    localparam int DVD_W   = NUM_W + FRAC_W;
    localparam int SCORE_W = 40;

    localparam logic [1:0] REG_METRIC    = 2'd0;
    localparam logic [1:0] REG_COUNT     = 2'd1;
    localparam logic [1:0] REG_WEIGHTING = 2'd2;

    localparam logic [2:0] METRIC_RESET = 3'd1;
    localparam logic [15:0] WEIGHT_ONE  = 16'd256;

    typedef enum logic [2:0] {
        METRIC_HAMMING   = 3'd0,
        METRIC_TANIMOTO  = 3'd1,
        METRIC_TV_REF    = 3'd2,
        METRIC_TV_COMP   = 3'd3,
        METRIC_DICE      = 3'd4,
        METRIC_SOERGEL   = 3'd5
    } metric_t;

    typedef struct packed {
        logic [7:0]  ref_value;
        logic [7:0]  comp_value;
        logic [15:0] weight;
        logic        last;
    } item_t;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic               zero_denominator;
    } result_t;

    // sums of one finished pair plus the mode it is scored under
    typedef struct packed {
        logic [SUM_W-1:0] sum_ref;
        logic [SUM_W-1:0] sum_comp;
        logic [SUM_W-1:0] sum_both;
        logic [SUM_W-1:0] sum_diff;
        logic [SUM_W-1:0] sum_max;
        logic [2:0]       metric;
        logic             count_mode;
    } snap_t;

endpackage

// ===== sv/fss_fifo.sv =====
`include "assert_macros.svh"

module fss_fifo #(
    parameter type T = logic
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  T           wdata,
    input  logic       pop,
    output T           rdata,
    output logic [1:0] count,
    output logic       full,
    output logic       empty
);

    T           mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign count   = count_reg;
    assign rdata   = mem[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    `ASSERT_IMPLIES(a_fifo_no_overflow, clk, rst_n, push && full, 1'b0, "fifo push while full")

endmodule

// ===== sv/fss_front.sv =====
`include "assert_macros.svh"

module fss_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  fss_pkg::item_t item,
    output logic          full,
    input  logic          count_mode,
    input  logic          weighting_on,
    input  logic [2:0]    metric,
    input  logic [1:0]    mid_count,
    output logic          mid_push,
    output fss_pkg::snap_t mid_data
);
    import fss_pkg::*;

    // stage 1: captured element
    logic        v1_reg;
    logic [7:0]  r1_reg, c1_reg;
    logic [15:0] w1_reg;
    logic        last1_reg, cm1_reg;
    // stage 2: first products
    logic        v2_reg;
    logic [7:0]  r2_reg, c2_reg;
    logic [15:0] w2_reg;
    logic [23:0] wr2_reg, wc2_reg, wd2_reg, wm2_reg;
    logic        last2_reg, cm2_reg;

    logic [SUM_W-1:0] sref_reg, scomp_reg, sboth_reg, sdiff_reg, smax_reg;
    logic [SUM_W-1:0] sref_next, scomp_next, sboth_next, sdiff_next, smax_next;

    logic [2:0]  pending;
    logic        accept;
    logic [7:0]  d1, m1;
    logic [31:0] add_ref, add_comp, add_both, add_diff, add_max;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] acc,
                                                 input logic [31:0] v);
        logic [SUM_W:0] s;
        s = {1'b0, acc} + {{(SUM_W-31){1'b0}}, v};
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

    // hold off while two finished pairs could already be waiting
    assign pending = {1'b0, mid_count} + {2'b0, v1_reg && last1_reg}
                   + {2'b0, v2_reg && last2_reg};
    assign full   = (pending >= 3'd2);
    assign accept = push && !full;

    assign d1 = (r1_reg > c1_reg) ? r1_reg - c1_reg : c1_reg - r1_reg;
    assign m1 = (r1_reg > c1_reg) ? r1_reg : c1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        r1_reg    <= item.ref_value;
        c1_reg    <= item.comp_value;
        w1_reg    <= weighting_on ? item.weight : WEIGHT_ONE;
        last1_reg <= item.last;
        cm1_reg   <= count_mode;
        r2_reg    <= r1_reg;
        c2_reg    <= c1_reg;
        w2_reg    <= w1_reg;
        wr2_reg   <= w1_reg * r1_reg;
        wc2_reg   <= w1_reg * c1_reg;
        wd2_reg   <= w1_reg * d1;
        wm2_reg   <= w1_reg * m1;
        last2_reg <= last1_reg;
        cm2_reg   <= cm1_reg;
    end

    always_comb
    begin
        add_ref  = '0;
        add_comp = '0;
        add_both = '0;
        add_diff = '0;
        add_max  = '0;
        if (cm2_reg)
        begin
            add_ref  = wr2_reg * r2_reg;
            add_comp = wc2_reg * c2_reg;
            add_both = wr2_reg * c2_reg;
            add_diff = {8'd0, wd2_reg};
            add_max  = {8'd0, wm2_reg};
        end
        else
        begin
            if (r2_reg != 8'd0 && c2_reg == 8'd0)
            begin
                add_ref = {16'd0, w2_reg};
            end
            if (r2_reg == 8'd0 && c2_reg != 8'd0)
            begin
                add_comp = {16'd0, w2_reg};
            end
            if (r2_reg != 8'd0 && c2_reg == r2_reg)
            begin
                add_both = {16'd0, w2_reg};
            end
        end
        sref_next  = sat_add(sref_reg, add_ref);
        scomp_next = sat_add(scomp_reg, add_comp);
        sboth_next = sat_add(sboth_reg, add_both);
        sdiff_next = sat_add(sdiff_reg, add_diff);
        smax_next  = sat_add(smax_reg, add_max);
    end

    assign mid_push            = v2_reg && last2_reg;
    assign mid_data.sum_ref    = sref_next;
    assign mid_data.sum_comp   = scomp_next;
    assign mid_data.sum_both   = sboth_next;
    assign mid_data.sum_diff   = sdiff_next;
    assign mid_data.sum_max    = smax_next;
    assign mid_data.metric     = metric;
    assign mid_data.count_mode = cm2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sref_reg  <= '0;
            scomp_reg <= '0;
            sboth_reg <= '0;
            sdiff_reg <= '0;
            smax_reg  <= '0;
        end
        else if (v2_reg)
        begin
            if (last2_reg)
            begin
                sref_reg  <= '0;
                scomp_reg <= '0;
                sboth_reg <= '0;
                sdiff_reg <= '0;
                smax_reg  <= '0;
            end
            else
            begin
                sref_reg  <= sref_next;
                scomp_reg <= scomp_next;
                sboth_reg <= sboth_next;
                sdiff_reg <= sdiff_next;
                smax_reg  <= smax_next;
            end
        end
    end

    `ASSERT_IMPLIES(a_front_room, clk, rst_n, mid_push, mid_count != 2'd2, "pair queue overrun")

endmodule

// ===== sv/fss_back.sv =====
`include "assert_macros.svh"

module fss_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            mid_empty,
    input  fss_pkg::snap_t  mid_data,
    output logic            mid_pop,
    input  logic            out_full,
    output logic            out_push,
    output fss_pkg::result_t out_data
);
    import fss_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [NUM_W-1:0]   den_reg, den_next;
    logic [NUM_W-1:0]   rem_reg, rem_next;
    logic [DVD_W-1:0]   dvd_reg, dvd_next;
    logic [DVD_W-1:0]   quo_reg, quo_next;
    logic [6:0]         cnt_reg, cnt_next;
    logic               ratio_reg, ratio_next;
    logic               zero_reg, zero_next;
    logic [SCORE_W-1:0] ham_reg, ham_next;

    logic [NUM_W-1:0] a, b, c, apb, c20, num_c, den_c;
    logic [NUM_W:0]   rem_sh;
    logic             ratio_c;
    logic [NUM_W-1:0] ham_c;

    assign a   = {{(NUM_W-SUM_W){1'b0}}, mid_data.sum_ref};
    assign b   = {{(NUM_W-SUM_W){1'b0}}, mid_data.sum_comp};
    assign c   = {{(NUM_W-SUM_W){1'b0}}, mid_data.sum_both};
    assign apb = a + b;
    assign c20 = (c << 4) + (c << 2);

    // numerator and denominator of the selected metric
    always_comb
    begin
        num_c   = '0;
        den_c   = '0;
        ratio_c = 1'b1;
        ham_c   = '0;
        case (metric_t'(mid_data.metric))
            METRIC_HAMMING:
            begin
                ratio_c = 1'b0;
                ham_c   = mid_data.count_mode
                        ? {{(NUM_W-SUM_W){1'b0}}, mid_data.sum_diff} : apb;
            end
            METRIC_TANIMOTO:
            begin
                num_c = c;
                if (mid_data.count_mode)
                begin
                    den_c = (apb > c) ? apb - c : '0;
                end
                else
                begin
                    den_c = apb + c;
                end
            end
            METRIC_TV_REF:
            begin
                num_c = c20;
                den_c = (a << 4) + (a << 1) + a + b + (mid_data.count_mode ? '0 : c20);
            end
            METRIC_TV_COMP:
            begin
                num_c = c20;
                den_c = a + (b << 4) + (b << 1) + b + (mid_data.count_mode ? '0 : c20);
            end
            METRIC_DICE:
            begin
                if (mid_data.count_mode)
                begin
                    num_c = (c << 1) + apb;
                    den_c = apb << 1;
                end
                else
                begin
                    num_c = c << 1;
                    den_c = apb + (c << 1);
                end
            end
            METRIC_SOERGEL:
            begin
                if (mid_data.count_mode)
                begin
                    num_c = (mid_data.sum_max > mid_data.sum_diff)
                          ? {{(NUM_W-SUM_W){1'b0}}, mid_data.sum_max - mid_data.sum_diff}
                          : '0;
                    den_c = {{(NUM_W-SUM_W){1'b0}}, mid_data.sum_max};
                end
                else
                begin
                    num_c = apb;
                    den_c = apb + c;
                end
            end
            default:
            begin
                ratio_c = 1'b0;
            end
        endcase
    end

    assign rem_sh = {rem_reg, dvd_reg[DVD_W-1]};

    always_comb
    begin
        state_next = state_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        dvd_next   = dvd_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        ratio_next = ratio_reg;
        zero_next  = zero_reg;
        ham_next   = ham_reg;
        mid_pop    = 1'b0;
        out_push   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!mid_empty)
                begin
                    mid_pop    = 1'b1;
                    den_next   = den_c;
                    rem_next   = '0;
                    dvd_next   = {num_c, {FRAC_W{1'b0}}};
                    quo_next   = '0;
                    cnt_next   = 7'(DVD_W - 1);
                    ratio_next = ratio_c;
                    zero_next  = ratio_c && (den_c == '0);
                    ham_next   = (ham_c[NUM_W-1:SCORE_W] != '0)
                               ? {SCORE_W{1'b1}} : ham_c[SCORE_W-1:0];
                    state_next = (ratio_c && den_c != '0) ? ST_DIV : ST_DONE;
                end
            end
            ST_DIV:
            begin
                // one quotient bit per cycle, restoring
                if (rem_sh >= {1'b0, den_reg})
                begin
                    rem_next = NUM_W'(rem_sh - {1'b0, den_reg});
                    quo_next = {quo_reg[DVD_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[NUM_W-1:0];
                    quo_next = {quo_reg[DVD_W-2:0], 1'b0};
                end
                dvd_next = dvd_reg << 1;
                cnt_next = cnt_reg - 7'd1;
                if (cnt_reg == 7'd0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_full)
                begin
                    out_push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_data.zero_denominator = zero_reg;
        if (!ratio_reg)
        begin
            out_data.score = ham_reg;
        end
        else if (zero_reg)
        begin
            out_data.score = '0;
        end
        else if (quo_reg[DVD_W-1:SCORE_W] != '0)
        begin
            out_data.score = {SCORE_W{1'b1}};
        end
        else
        begin
            out_data.score = quo_reg[SCORE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg   <= den_next;
        rem_reg   <= rem_next;
        dvd_reg   <= dvd_next;
        quo_reg   <= quo_next;
        cnt_reg   <= cnt_next;
        ratio_reg <= ratio_next;
        zero_reg  <= zero_next;
        ham_reg   <= ham_next;
    end

    `ASSERT_IMPLIES(a_back_push_room, clk, rst_n, out_push, !out_full, "result queue overrun")
    `ASSERT_NEXT(a_back_div_end, clk, rst_n, state_reg == ST_DIV && cnt_reg == 7'd0, state_reg == ST_DONE, "divide did not finish")
    `ASSERT_IMPLIES(a_back_zero_score, clk, rst_n, out_push && out_data.zero_denominator, out_data.score == '0, "zero denominator with nonzero score")

endmodule

// ===== sv/fingerprint_similarity_scorer.sv =====
// fingerprint similarity scorer
// input channel: push/full with one element pair per beat (ref, comp,
//   weight, last); a beat is taken when push is high and full is low
// result channel: empty/pop; the oldest score sits on result while empty
//   is low and leaves when pop is high
// elements stream in at one beat per cycle, while full is low, into
//   saturating accumulators; the beat marked last closes the pair and
//   gives exactly one result, which passes two accumulate stages, a
//   setup step and a 70-step restoring divider that yields one quotient
//   bit per cycle, then the result queue
// the divider takes a new pair only after handing off the last (setup,
//   70 divide steps, hand-off); hamming and spare codes skip the divide;
//   two closed pairs may wait ahead of it, beyond that full stays high
// a receiver that stalls fills the two-entry result queue, then the
//   divider holds, then the pair queue fills, then full is raised
// reset clears the sums, the queues and the registers (metric tanimoto,
//   binary mode, weights off)
// configuration: cfg_wr_en/cfg_index/cfg_wdata, to be written only while idle; the block does not enforce it
module fingerprint_similarity_scorer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  fss_pkg::item_t    item,
    output logic              empty,
    input  logic              pop,
    output fss_pkg::result_t  result,
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_index,
    input  logic [2:0]        cfg_wdata
);
    import fss_pkg::*;

    logic [2:0] metric_reg;
    logic       count_mode_reg;
    logic       weighting_reg;

    // pair queue between front and back
    logic       mid_push, mid_pop, mid_full, mid_empty;
    logic [1:0] mid_count;
    snap_t      mid_wdata, mid_rdata;

    // result queue
    logic       out_push, out_full;
    logic [1:0] out_count;
    result_t    out_wdata;

    // register writes, unknown index ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            metric_reg     <= METRIC_RESET;
            count_mode_reg <= 1'b0;
            weighting_reg  <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_METRIC:    metric_reg     <= cfg_wdata;
                REG_COUNT:     count_mode_reg <= cfg_wdata[0];
                REG_WEIGHTING: weighting_reg  <= cfg_wdata[0];
                default:       ;
            endcase
        end
    end

    // accumulate front end
    fss_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .item         (item),
        .full         (full),
        .count_mode   (count_mode_reg),
        .weighting_on (weighting_reg),
        .metric       (metric_reg),
        .mid_count    (mid_count),
        .mid_push     (mid_push),
        .mid_data     (mid_wdata)
    );

    fss_fifo #(.T(snap_t)) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_push),
        .wdata (mid_wdata),
        .pop   (mid_pop),
        .rdata (mid_rdata),
        .count (mid_count),
        .full  (mid_full),
        .empty (mid_empty)
    );

    // scoring back end with the divider
    fss_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_empty (mid_empty),
        .mid_data  (mid_rdata),
        .mid_pop   (mid_pop),
        .out_full  (out_full),
        .out_push  (out_push),
        .out_data  (out_wdata)
    );

    fss_fifo #(.T(result_t)) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (out_wdata),
        .pop   (pop),
        .rdata (result),
        .count (out_count),
        .full  (out_full),
        .empty (empty)
    );

    `ASSERT_IMPLIES(a_top_mid_guard, clk, rst_n, mid_full, full, "pair queue full but input open")
    `ASSERT_IMPLIES(a_top_out_count, clk, rst_n, !empty, out_count != 2'd0, "result shown from empty queue")

endmodule

// ===== tb/testbench.sv =====
module testbench;
    import fss_pkg::*;

    // codes 6 and 7 are not named in the package but the register takes them
    localparam logic [2:0] METRIC_SPARE_LO = 3'd6;
    localparam logic [2:0] METRIC_SPARE_HI = 3'd7;
    localparam longint unsigned SUM_MAX   = 64'hFFFF_FFFF_FFFF;
    localparam longint unsigned SCORE_MAX = 64'hFF_FFFF_FFFF;
    localparam int DRAIN_CYCLES  = 100;     // a little over the pipeline latency
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_ITEMS  = 1050;
    localparam int NSTEP         = 25;

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    item_t item;
    logic empty;
    logic pop;
    result_t result;
    logic cfg_wr_en;
    logic [1:0] cfg_index;
    logic [2:0] cfg_wdata;

    fingerprint_similarity_scorer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // clock: 10 units, low then high
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // scoring model: own copy of the registers and the five pair sums
    // ------------------------------------------------------------------
    logic [2:0] sel_metric;
    logic       sel_count;
    logic       sel_weighting;
    longint unsigned acc_only_ref, acc_only_comp, acc_both, acc_diff, acc_max;

    result_t scores_due [$];   // scores still owed by the block, oldest first
    int      error_count;
    int      cycle_count;
    int      send_idle_pct;
    int      recv_idle_pct;

    function automatic longint unsigned sat_add(longint unsigned acc, longint unsigned v);
        longint unsigned s;
        s = acc + v;
        return (s > SUM_MAX) ? SUM_MAX : s;
    endfunction

    // truncated num/den in Q24.16 by long division, clipped to 40 bits
    function automatic longint unsigned q16_quotient(longint unsigned num,
                                                     longint unsigned den);
        longint unsigned q;
        longint unsigned rem;
        longint unsigned frac;
        q = num / den;
        rem = num % den;
        frac = 0;
        if (q >= (64'd1 << 24))
            return SCORE_MAX;
        for (int i = 0; i < 16; i++)
        begin
            rem = rem << 1;
            frac = frac << 1;
            if (rem >= den)
            begin
                rem = rem - den;
                frac = frac | 64'd1;
            end
        end
        return (q << 16) | frac;
    endfunction

    // fold one accepted beat into the sums; on the closing beat work out its score
    function automatic bit score_beat(item_t it, output result_t res);
        longint unsigned r, c, w, a, b, ab, num, den, val;
        bit ratio;
        r = it.ref_value;
        c = it.comp_value;
        w = sel_weighting ? longint'(it.weight) : longint'(WEIGHT_ONE);
        num = 0;
        den = 0;
        val = 0;
        ratio = 1'b1;
        res = '0;
        if (sel_count)
        begin
            acc_only_ref  = sat_add(acc_only_ref, w * r * r);
            acc_only_comp = sat_add(acc_only_comp, w * c * c);
            acc_both      = sat_add(acc_both, w * r * c);
            acc_diff      = sat_add(acc_diff, w * ((r > c) ? r - c : c - r));
            acc_max       = sat_add(acc_max, w * ((r > c) ? r : c));
        end
        else
        begin
            // unequal nonzero elements land in no sum at all
            if (r != 0 && c == 0)
                acc_only_ref = sat_add(acc_only_ref, w);
            if (r == 0 && c != 0)
                acc_only_comp = sat_add(acc_only_comp, w);
            if (r != 0 && c == r)
                acc_both = sat_add(acc_both, w);
        end
        if (!it.last)
            return 1'b0;

        a = acc_only_ref;
        b = acc_only_comp;
        ab = acc_both;
        case (sel_metric)
            METRIC_HAMMING:
            begin
                ratio = 1'b0;
                val = sel_count ? acc_diff : a + b;
                if (val > SCORE_MAX)
                    val = SCORE_MAX;
            end
            METRIC_TANIMOTO:
            begin
                num = ab;
                den = sel_count ? ((a + b > ab) ? a + b - ab : 0) : a + b + ab;
            end
            METRIC_TV_REF:
            begin
                // 0.95 and 0.05 scaled by 20
                num = 20 * ab;
                den = sel_count ? 19 * a + b : 19 * a + b + 20 * ab;
            end
            METRIC_TV_COMP:
            begin
                num = 20 * ab;
                den = sel_count ? a + 19 * b : a + 19 * b + 20 * ab;
            end
            METRIC_DICE:
            begin
                num = sel_count ? 2 * ab + a + b : 2 * ab;
                den = sel_count ? 2 * (a + b) : a + b + 2 * ab;
            end
            METRIC_SOERGEL:
            begin
                num = sel_count ? ((acc_max > acc_diff) ? acc_max - acc_diff : 0) : a + b;
                den = sel_count ? acc_max : a + b + ab;
            end
            default:
            begin
                ratio = 1'b0;
                val = 0;
            end
        endcase
        if (ratio)
        begin
            if (den == 0)
                res.zero_denominator = 1'b1;
            else
                val = q16_quotient(num, den);
        end
        res.score = val[SCORE_W-1:0];
        acc_only_ref = 0;
        acc_only_comp = 0;
        acc_both = 0;
        acc_diff = 0;
        acc_max = 0;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    task automatic report(string what, longint unsigned want, longint unsigned got);
        $display("mismatch at cycle %0d: %s expected %0d got %0d",
                 cycle_count, what, want, got);
        error_count++;
    endtask

    // result side: random pop, compare each popped beat with the oldest score due
    always @(negedge clk)
    begin
        if (rst_n)
            pop <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        result_t due;
        if (rst_n && pop && !empty)
        begin
            if (scores_due.size() == 0)
                report("unexpected result beat, score", 0, result.score);
            else
            begin
                due = scores_due.pop_front();
                if (result.score !== due.score)
                    report("score", due.score, result.score);
                if (result.zero_denominator !== due.zero_denominator)
                    report("zero_denominator", due.zero_denominator,
                           result.zero_denominator);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------
    // one beat: optional random gap, then hold push until full is low
    task automatic send_beat(item_t it, bit typed, result_t typed_res);
        result_t res;
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            push <= 1'b0;
        end
        @(negedge clk);
        push <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (full);
        if (score_beat(it, res))
            scores_due.push_back(typed ? typed_res : res);
    endtask

    // registers change only once everything in flight has drained
    task automatic set_mode(logic [2:0] m, logic cnt, logic wt);
        @(negedge clk);
        push <= 1'b0;
        wait (scores_due.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_METRIC;
        cfg_wdata <= m;
        @(negedge clk);
        cfg_index <= REG_COUNT;
        cfg_wdata <= {2'b00, cnt};
        @(negedge clk);
        cfg_index <= REG_WEIGHTING;
        cfg_wdata <= {2'b00, wt};
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        sel_metric = m;
        sel_count = cnt;
        sel_weighting = wt;
    endtask

    // one element value pair with the special cases weighted in
    task automatic pick_elements(output logic [7:0] r, output logic [7:0] c);
        int kind;
        kind = $urandom_range(9);
        r = 8'($urandom_range(255));
        c = 8'($urandom_range(255));
        if (!sel_count)
        begin
            // binary: mostly presence bits, sometimes equal or unequal counts
            case (kind)
                0, 1: begin r = 8'd0; c = 8'd0; end
                2, 3: begin r = 8'd1; c = 8'd1; end
                4:    begin r = (r == 8'd0) ? 8'd1 : r; c = r; end
                5, 6: begin r = (r == 8'd0) ? 8'd255 : r; c = 8'd0; end
                7, 8: begin r = 8'd0; c = (c == 8'd0) ? 8'd255 : c; end
                default: ;  // unequal nonzero now and then
            endcase
        end
        else if (kind == 0)
        begin
            r = $urandom_range(1) ? 8'd255 : 8'd0;
            c = $urandom_range(1) ? 8'd255 : 8'd0;
        end
    endtask

    // ------------------------------------------------------------------
    // directed table: optional register setting, one beat, typed score if obvious
    // ------------------------------------------------------------------
    typedef struct packed {
        bit          cfg;
        logic [2:0]  metric;
        logic        cnt;
        logic        wt;
        item_t       it;
        bit          typed;
        result_t     res;
    } step_t;

    step_t steps [0:NSTEP-1];

    initial
    begin
        item_t it;
        result_t none;
        int sent;
        int len;

        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        item = '0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_METRIC;
        cfg_wdata = '0;
        error_count = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        none = '0;
        sel_metric = METRIC_RESET;
        sel_count = 1'b0;
        sel_weighting = 1'b0;
        acc_only_ref = 0;
        acc_only_comp = 0;
        acc_both = 0;
        acc_diff = 0;
        acc_max = 0;

        steps = '{
            // after reset: tanimoto, binary, weight one
            '{1'b0, METRIC_TANIMOTO, 1'b0, 1'b0, '{8'd1, 8'd1, 16'd0, 1'b1},
              1'b1, '{40'd65536, 1'b0}},
            '{1'b0, METRIC_TANIMOTO, 1'b0, 1'b0, '{8'd0, 8'd0, 16'd0, 1'b1},
              1'b1, '{40'd0, 1'b1}},
            // unequal nonzero counts nowhere, so empty denominator
            '{1'b0, METRIC_TANIMOTO, 1'b0, 1'b0, '{8'd3, 8'd5, 16'd0, 1'b1},
              1'b1, '{40'd0, 1'b1}},
            '{1'b1, METRIC_HAMMING, 1'b0, 1'b0, '{8'd255, 8'd0, 16'hFFFF, 1'b0},
              1'b0, '{40'd0, 1'b0}},
            '{1'b0, METRIC_HAMMING, 1'b0, 1'b0, '{8'd0, 8'd255, 16'd0, 1'b1},
              1'b1, '{40'd512, 1'b0}},
            // spare metric codes score nothing
            '{1'b1, METRIC_SPARE_LO, 1'b0, 1'b0, '{8'd1, 8'd1, 16'd0, 1'b1},
              1'b1, '{40'd0, 1'b0}},
            '{1'b1, METRIC_SPARE_HI, 1'b1, 1'b1, '{8'd9, 8'd3, 16'd7, 1'b1},
              1'b1, '{40'd0, 1'b0}},
            // largest single hamming term: 65535 * 255
            '{1'b1, METRIC_HAMMING, 1'b1, 1'b1, '{8'd255, 8'd0, 16'hFFFF, 1'b1},
              1'b1, '{40'd16711425, 1'b0}},
            '{1'b1, METRIC_SOERGEL, 1'b1, 1'b1, '{8'd0, 8'd0, 16'hFFFF, 1'b1},
              1'b1, '{40'd0, 1'b1}},
            '{1'b0, METRIC_SOERGEL, 1'b1, 1'b1, '{8'd255, 8'd255, 16'hFFFF, 1'b0},
              1'b0, '{40'd0, 1'b0}},
            '{1'b0, METRIC_SOERGEL, 1'b1, 1'b1, '{8'd0, 8'd255, 16'd1, 1'b1},
              1'b0, '{40'd0, 1'b0}},
            '{1'b1, METRIC_TV_REF, 1'b0, 1'b1, '{8'd1, 8'd1, 16'hFFFF, 1'b0},
              1'b0, '{40'd0, 1'b0}},
            '{1'b0, METRIC_TV_REF, 1'b0, 1'b1, '{8'd2, 8'd0, 16'd256, 1'b0},
              1'b0, '{40'd0, 1'b0}},
            '{1'b0, METRIC_TV_REF, 1'b0, 1'b1, '{8'd0, 8'd7, 16'd128, 1'b1},
              1'b0, '{40'd0, 1'b0}},
            '{1'b1, METRIC_TV_COMP, 1'b0, 1'b1, '{8'd5, 8'd5, 16'd300, 1'b0},
              1'b0, '{40'd0, 1'b0}},
            '{1'b0, METRIC_TV_COMP, 1'b0, 1'b1, '{8'd0, 8'd1, 16'd9, 1'b1},
              1'b0, '{40'd0, 1'b0}},
            '{1'b1, METRIC_TV_COMP, 1'b1, 1'b0, '{8'd40, 8'd90, 16'd0, 1'b1},
              1'b0, '{40'd0, 1'b0}},
            '{1'b1, METRIC_DICE, 1'b1, 1'b0, '{8'd200, 8'd100, 16'd0, 1'b0},
              1'b0, '{40'd0, 1'b0}},
            '{1'b0, METRIC_DICE, 1'b1, 1'b0, '{8'd7, 8'd0, 16'd0, 1'b1},
              1'b0, '{40'd0, 1'b0}},
            '{1'b1, METRIC_DICE, 1'b0, 1'b0, '{8'd1, 8'd1, 16'd0, 1'b0},
              1'b0, '{40'd0, 1'b0}},
            '{1'b0, METRIC_DICE, 1'b0, 1'b0, '{8'd0, 8'd1, 16'd0, 1'b1},
              1'b0, '{40'd0, 1'b0}},
            // mode switched half way through a pair
            '{1'b1, METRIC_TANIMOTO, 1'b1, 1'b1, '{8'd10, 8'd20, 16'd1000, 1'b0},
              1'b0, '{40'd0, 1'b0}},
            '{1'b1, METRIC_TANIMOTO, 1'b0, 1'b1, '{8'd3, 8'd3, 16'd500, 1'b1},
              1'b0, '{40'd0, 1'b0}},
            '{1'b1, METRIC_SOERGEL, 1'b0, 1'b0, '{8'd4, 8'd0, 16'd0, 1'b0},
              1'b0, '{40'd0, 1'b0}},
            '{1'b0, METRIC_SOERGEL, 1'b0, 1'b0, '{8'd4, 8'd4, 16'd0, 1'b1},
              1'b0, '{40'd0, 1'b0}}
        };

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < NSTEP; i++)
        begin
            if (steps[i].cfg)
                set_mode(steps[i].metric, steps[i].cnt, steps[i].wt);
            send_beat(steps[i].it, steps[i].typed, steps[i].res);
        end

        // random pairs in three idling phases: receiver-heavy, sender-heavy, none
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent < RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 22;
                recv_idle_pct = 49;
            end
            else if (sent < 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 49;
                recv_idle_pct = 22;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if ($urandom_range(3) == 0)
                set_mode(3'($urandom_range(7)), 1'($urandom_range(1)),
                         1'($urandom_range(1)));
            // mostly short pairs, a few long ones
            len = ($urandom_range(9) == 0) ? $urandom_range(60, 13) : $urandom_range(12, 1);
            for (int k = 0; k < len; k++)
            begin
                pick_elements(it.ref_value, it.comp_value);
                case ($urandom_range(7))
                    0:       it.weight = 16'hFFFF;
                    1:       it.weight = 16'd0;
                    2:       it.weight = WEIGHT_ONE;
                    default: it.weight = 16'($urandom_range(16'hFFFF));
                endcase
                it.last = (k == len - 1);
                send_beat(it, 1'b0, none);
                sent++;
            end
        end

        @(negedge clk);
        push <= 1'b0;
        wait (scores_due.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
